### hw/rtl/serial_servo_frame_engine_core_assert.svh
// Assertion helpers for the servo frame engine. Both use clk and rst_n of the
// module that expands them.
`ifndef SERIAL_SERVO_FRAME_ENGINE_CORE_ASSERT_SVH
`define SERIAL_SERVO_FRAME_ENGINE_CORE_ASSERT_SVH

// Condition must never be true outside reset.
`define SSV_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define SSV_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/sserv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sserv_pkg;

    // Request action codes
    typedef enum logic [2:0] {
        ACT_MOVE   = 3'd0,
        ACT_LOAD   = 3'd1,
        ACT_UNLOAD = 3'd2,
        ACT_READ   = 3'd3,
        ACT_RX     = 3'd4,
        ACT_TICK   = 3'd5
    } act_t;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_POS     = 2'd1,
        KIND_CKERR   = 2'd2,
        KIND_TIMEOUT = 2'd3
    } kind_t;

    // Work handed from front to back
    typedef enum logic [2:0] {
        OP_MOVE,
        OP_LOAD,
        OP_UNLOAD,
        OP_READ,
        OP_POS,
        OP_CKERR,
        OP_TIMEOUT
    } op_t;

    localparam int MOVE_Q_W = 14;

    typedef struct packed {
        op_t                   op;
        logic [7:0]            id;
        logic [MOVE_Q_W-1:0]   move_q;   // servo position, not yet clamped to POS_MAX
        logic [15:0]           raw;
        logic [14:0]           deg;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Frame bytes
    localparam logic [7:0] SYNC_BYTE  = 8'h55;
    localparam logic [7:0] LEN_MOVE   = 8'h07;
    localparam logic [7:0] LEN_LOAD   = 8'h04;
    localparam logic [7:0] LEN_READ   = 8'h03;
    localparam logic [7:0] OPC_MOVE   = 8'h01;
    localparam logic [7:0] OPC_LOAD   = 8'h1F;
    localparam logic [7:0] OPC_READ   = 8'h1C;
    localparam logic [7:0] REPLY_MARK = 8'h1C;
    localparam logic [7:0] REPLY_SUM  = 8'h21;   // reply length plus opcode

    // Degrees to servo units: floor(s*25/6) == (s*MOVE_RECIP) >> 16 for s < 32768
    localparam logic signed [12:0] ANGLE_BIAS = 13'sd120;
    localparam logic [18:0]        MOVE_RECIP = 19'd273067;
    localparam logic [MOVE_Q_W-1:0] POS_MAX   = 14'd1000;

    // Servo units to degrees: floor(6*raw/25) == (raw*DEG_RECIP) >> 23
    localparam logic [20:0] DEG_RECIP    = 21'd2013270;
    localparam logic [22:0] DEG_FRAC_MIN = 23'd335545;   // nonzero remainder
    localparam logic [14:0] DEG_BIAS     = 15'd120;
    localparam logic [15:0] NEG_LIMIT    = 16'd500;      // below: negative degrees

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

endpackage

`default_nettype wire

### hw/rtl/serial_servo_frame_engine_core.sv
// Channel   | Handshake             | Payload
// ----------+-----------------------+----------------------------------------------
// request   | cmd_valid / cmd_stall | action, servo_id, angle, rx_byte
// result    | res_valid / res_stall | kind, tx_byte, last_byte, raw_position,
//           |                       | position_degrees
// config    | timeout_we            | timeout_data (reply timeout, ticks)
//
// A request is taken every cycle while the four-entry work queue has room;
// received bytes and ticks that give no result do not enter the queue.
// While work is queued and res_stall is low, the back end sends one result per
// cycle; a move frame is 10 results, load and unload 7, a read 6, and a reply,
// checksum error or timeout 1.
// Reset is asynchronous, active low; the timeout register resets to 5000.
// A stalled result holds in the output register while requests keep queueing.
`timescale 1ns / 1ps
`default_nettype none

`include "serial_servo_frame_engine_core_assert.svh"

module serial_servo_frame_engine_core
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cmd_valid,
    output logic                      cmd_stall,
    input  wire logic [2:0]           action,
    input  wire logic [7:0]           servo_id,
    input  wire logic signed [11:0]   angle,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 timeout_we,
    input  wire logic [15:0]          timeout_data,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output logic [1:0]                kind,
    output logic [7:0]                tx_byte,
    output logic                      last_byte,
    output logic [15:0]               raw_position,
    output logic signed [14:0]        position_degrees
);

    logic               accept;
    logic               q_push;
    logic               q_pop;
    sserv_pkg::cmd_t    q_wdata;
    sserv_pkg::cmd_t    q_head;
    sserv_pkg::q_stat_t q_stat;
    sserv_pkg::kind_t   kind_out;
    logic               is_report;
    logic               report_clean;

    assign cmd_stall = q_stat.full;
    assign accept    = cmd_valid && !cmd_stall;
    assign kind      = kind_out;

    // Front: request decode and reply tracking
    sserv_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .servo_id     (servo_id),
        .angle        (angle),
        .rx_byte      (rx_byte),
        .timeout_we   (timeout_we),
        .timeout_data (timeout_data),
        .push         (q_push),
        .push_data    (q_wdata)
    );

    // Work queue
    sserv_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    // Back: frame serializer and result register
    sserv_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .head             (q_head),
        .stat             (q_stat),
        .pop              (q_pop),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .kind             (kind_out),
        .tx_byte          (tx_byte),
        .last_byte        (last_byte),
        .raw_position     (raw_position),
        .position_degrees (position_degrees)
    );

    // Checks
    assign is_report    = res_valid && (kind_out != sserv_pkg::KIND_TX);
    assign report_clean = !last_byte && (tx_byte == 8'd0);

    `SSV_ASSERT_NEVER(a_no_push_full, q_push && q_stat.full, "push into full queue")
    `SSV_ASSERT_NEVER(a_no_pop_empty, q_pop && q_stat.empty, "pop from empty queue")
    `SSV_ASSERT_IMPLY(a_report_clean, is_report, report_clean, "report carries frame byte")

endmodule

`default_nettype wire

### hw/rtl/sserv_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sserv_front
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 accept,
    input  wire logic [2:0]           action,
    input  wire logic [7:0]           servo_id,
    input  wire logic signed [11:0]   angle,
    input  wire logic [7:0]           rx_byte,
    input  wire logic                 timeout_we,
    input  wire logic [15:0]          timeout_data,
    output logic                      push,
    output sserv_pkg::cmd_t           push_data
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_LOW,
        PH_HIGH,
        PH_CK
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic [7:0]  pending_id_reg, pending_id_next;
    logic [7:0]  low_reg,        low_next;
    logic [7:0]  high_reg,       high_next;
    logic [15:0] wait_reg,       wait_next;
    logic [36:0] prod_reg,       prod_next;
    logic [15:0] timeout_reg;

    logic signed [12:0] bias_sum;
    logic [11:0]        move_op;
    logic [30:0]        move_prod;
    logic [36:0]        deg_prod;
    logic [15:0]        raw_held;
    logic [13:0]        deg_q;
    logic               deg_fix;
    logic [14:0]        deg_val;
    logic [7:0]         reply_ck;

    // Move target: clamp negatives before the multiply, top clamp in the back
    assign bias_sum  = $signed({angle[11], angle}) + sserv_pkg::ANGLE_BIAS;
    assign move_op   = (bias_sum > 13'sd0) ? bias_sum[11:0] : 12'd0;
    assign move_prod = {19'd0, move_op} * {12'd0, sserv_pkg::MOVE_RECIP};

    // Degrees product taken when the high byte arrives
    assign deg_prod = {21'd0, rx_byte, low_reg} * {16'd0, sserv_pkg::DEG_RECIP};

    // Degrees from the stored product; round up toward zero when negative
    assign raw_held = {high_reg, low_reg};
    assign deg_q    = prod_reg[36:23];
    assign deg_fix  = (raw_held < sserv_pkg::NEG_LIMIT)
                      && (prod_reg[22:0] >= sserv_pkg::DEG_FRAC_MIN);
    assign deg_val  = {1'b0, deg_q} - sserv_pkg::DEG_BIAS + {14'd0, deg_fix};

    assign reply_ck = ~(pending_id_reg + sserv_pkg::REPLY_SUM + low_reg + high_reg);

    // Classify the request and update the reply tracker
    always_comb
    begin
        phase_next      = phase_reg;
        pending_id_next = pending_id_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        wait_next       = wait_reg;
        prod_next       = prod_reg;
        push            = 1'b0;
        push_data       = '0;
        push_data.id    = servo_id;
        push_data.move_q = move_prod[29:16];

        if (accept)
        begin
            case (action)
                sserv_pkg::ACT_MOVE:
                begin
                    push         = 1'b1;
                    push_data.op = sserv_pkg::OP_MOVE;
                end
                sserv_pkg::ACT_LOAD:
                begin
                    push         = 1'b1;
                    push_data.op = sserv_pkg::OP_LOAD;
                end
                sserv_pkg::ACT_UNLOAD:
                begin
                    push         = 1'b1;
                    push_data.op = sserv_pkg::OP_UNLOAD;
                end
                sserv_pkg::ACT_READ:
                begin
                    push            = 1'b1;
                    push_data.op    = sserv_pkg::OP_READ;
                    phase_next      = PH_HUNT;
                    pending_id_next = servo_id;
                    low_next        = 8'd0;
                    high_next       = 8'd0;
                    wait_next       = 16'd0;
                end
                sserv_pkg::ACT_RX:
                begin
                    case (phase_reg)
                        PH_HUNT:
                        begin
                            if (rx_byte == sserv_pkg::REPLY_MARK)
                            begin
                                phase_next = PH_LOW;
                            end
                        end
                        PH_LOW:
                        begin
                            low_next   = rx_byte;
                            phase_next = PH_HIGH;
                        end
                        PH_HIGH:
                        begin
                            high_next  = rx_byte;
                            prod_next  = deg_prod;
                            phase_next = PH_CK;
                        end
                        PH_CK:
                        begin
                            phase_next = PH_IDLE;
                            push       = 1'b1;
                            if (reply_ck == rx_byte)
                            begin
                                push_data.op  = sserv_pkg::OP_POS;
                                push_data.raw = raw_held;
                                push_data.deg = deg_val;
                            end
                            else
                            begin
                                push_data.op = sserv_pkg::OP_CKERR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                sserv_pkg::ACT_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (wait_reg >= timeout_reg)
                        begin
                            phase_next   = PH_IDLE;
                            push         = 1'b1;
                            push_data.op = sserv_pkg::OP_TIMEOUT;
                        end
                        else
                        begin
                            wait_next = wait_reg + 16'd1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pending_id_reg <= 8'd0;
            low_reg        <= 8'd0;
            high_reg       <= 8'd0;
            wait_reg       <= 16'd0;
            timeout_reg    <= sserv_pkg::TIMEOUT_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            pending_id_reg <= pending_id_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            wait_reg       <= wait_next;
            if (timeout_we)
            begin
                timeout_reg <= timeout_data;
            end
        end
    end

    // Product register holds data only
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

### hw/rtl/sserv_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sserv_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire sserv_pkg::cmd_t      push_data,
    input  wire logic                 pop,
    output sserv_pkg::cmd_t           head,
    output sserv_pkg::q_stat_t        stat
);

    sserv_pkg::cmd_t entry_reg [sserv_pkg::QDEPTH];

    logic [sserv_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sserv_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sserv_pkg::QCNT_W-1:0] count_reg,  count_next;

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == sserv_pkg::QCNT_W'(sserv_pkg::QDEPTH));
    assign stat.empty = (count_reg == '0);

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sserv_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sserv_back
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sserv_pkg::cmd_t      head,
    input  wire sserv_pkg::q_stat_t   stat,
    output logic                      pop,
    output logic                      res_valid,
    input  wire logic                 res_stall,
    output sserv_pkg::kind_t          kind,
    output logic [7:0]                tx_byte,
    output logic                      last_byte,
    output logic [15:0]               raw_position,
    output logic signed [14:0]        position_degrees
);

    sserv_pkg::cmd_t  cur_reg;
    logic             cur_valid_reg;
    logic [3:0]       idx_reg;

    logic             res_valid_reg;
    sserv_pkg::kind_t kind_reg;
    logic [7:0]       tx_reg;
    logic             last_reg;
    logic [15:0]      raw_reg;
    logic [14:0]      deg_reg;

    logic             adv;
    logic             at_last;
    logic [3:0]       last_idx;
    logic [9:0]       pos;
    logic [7:0]       pos_lo;
    logic [7:0]       pos_hi;
    logic [7:0]       ck;
    sserv_pkg::kind_t kind_cur;
    logic [7:0]       byte_cur;

    // Clamp the servo position and split it
    assign pos    = (cur_reg.move_q > sserv_pkg::POS_MAX) ? sserv_pkg::POS_MAX[9:0]
                                                          : cur_reg.move_q[9:0];
    assign pos_lo = pos[7:0];
    assign pos_hi = {6'd0, pos[9:8]};

    // Frame length and checksum per work type
    always_comb
    begin
        case (cur_reg.op)
            sserv_pkg::OP_MOVE:
            begin
                last_idx = 4'd9;
                ck = ~(cur_reg.id + sserv_pkg::LEN_MOVE + sserv_pkg::OPC_MOVE
                       + pos_lo + pos_hi);
            end
            sserv_pkg::OP_LOAD:
            begin
                last_idx = 4'd6;
                ck = ~(cur_reg.id + sserv_pkg::LEN_LOAD + sserv_pkg::OPC_LOAD + 8'd1);
            end
            sserv_pkg::OP_UNLOAD:
            begin
                last_idx = 4'd6;
                ck = ~(cur_reg.id + sserv_pkg::LEN_LOAD + sserv_pkg::OPC_LOAD);
            end
            sserv_pkg::OP_READ:
            begin
                last_idx = 4'd5;
                ck = ~(cur_reg.id + sserv_pkg::LEN_READ + sserv_pkg::OPC_READ);
            end
            default:
            begin
                last_idx = 4'd0;
                ck       = 8'd0;
            end
        endcase
    end

    // Byte at the current frame position
    always_comb
    begin
        kind_cur = sserv_pkg::KIND_TX;
        byte_cur = 8'd0;
        case (cur_reg.op)
            sserv_pkg::OP_MOVE:
            begin
                case (idx_reg)
                    4'd0, 4'd1: byte_cur = sserv_pkg::SYNC_BYTE;
                    4'd2:       byte_cur = cur_reg.id;
                    4'd3:       byte_cur = sserv_pkg::LEN_MOVE;
                    4'd4:       byte_cur = sserv_pkg::OPC_MOVE;
                    4'd5:       byte_cur = pos_lo;
                    4'd6:       byte_cur = pos_hi;
                    4'd9:       byte_cur = ck;
                    default:    byte_cur = 8'd0;
                endcase
            end
            sserv_pkg::OP_LOAD, sserv_pkg::OP_UNLOAD:
            begin
                case (idx_reg)
                    4'd0, 4'd1: byte_cur = sserv_pkg::SYNC_BYTE;
                    4'd2:       byte_cur = cur_reg.id;
                    4'd3:       byte_cur = sserv_pkg::LEN_LOAD;
                    4'd4:       byte_cur = sserv_pkg::OPC_LOAD;
                    4'd5:       byte_cur = (cur_reg.op == sserv_pkg::OP_LOAD) ? 8'd1 : 8'd0;
                    4'd6:       byte_cur = ck;
                    default:    byte_cur = 8'd0;
                endcase
            end
            sserv_pkg::OP_READ:
            begin
                case (idx_reg)
                    4'd0, 4'd1: byte_cur = sserv_pkg::SYNC_BYTE;
                    4'd2:       byte_cur = cur_reg.id;
                    4'd3:       byte_cur = sserv_pkg::LEN_READ;
                    4'd4:       byte_cur = sserv_pkg::OPC_READ;
                    4'd5:       byte_cur = ck;
                    default:    byte_cur = 8'd0;
                endcase
            end
            sserv_pkg::OP_POS:     kind_cur = sserv_pkg::KIND_POS;
            sserv_pkg::OP_CKERR:   kind_cur = sserv_pkg::KIND_CKERR;
            sserv_pkg::OP_TIMEOUT: kind_cur = sserv_pkg::KIND_TIMEOUT;
            default:               kind_cur = sserv_pkg::KIND_TX;
        endcase
    end

    // Advance when the output register is free or being drained
    assign adv     = cur_valid_reg && (!res_valid_reg || !res_stall);
    assign at_last = (idx_reg == last_idx);
    assign pop     = !stat.empty && (!cur_valid_reg || (adv && at_last));

    // Work register and byte counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= 4'd0;
            end
            else if (adv && at_last)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (adv)
            begin
                idx_reg <= idx_reg + 4'd1;
            end

            if (adv)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (adv)
        begin
            kind_reg <= kind_cur;
            tx_reg   <= byte_cur;
            last_reg <= (kind_cur == sserv_pkg::KIND_TX) && at_last;
            raw_reg  <= cur_reg.raw;
            deg_reg  <= cur_reg.deg;
        end
    end

    assign res_valid        = res_valid_reg;
    assign kind             = kind_reg;
    assign tx_byte          = tx_reg;
    assign last_byte        = last_reg;
    assign raw_position     = raw_reg;
    assign position_degrees = $signed(deg_reg);

endmodule

`default_nettype wire
